@@ sv/softmax_vector_unit_macros.svh @@
// Assertion macros for the softmax vector unit.
`ifndef SOFTMAX_VECTOR_UNIT_MACROS_SVH
`define SOFTMAX_VECTOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define SVU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svu assertion failed");
// Next-cycle implication.
`define SVU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svu assertion failed");
`else
`define SVU_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SVU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/svu_pkg.sv @@
// Types and constants shared by the softmax vector unit and its users.
package svu_pkg;

    localparam int DEF_MAX_LEN        = 64;
    localparam int DEF_EXP_TABLE_SIZE = 256;

    localparam int LOGIT_W = 16;
    localparam int PROB_W  = 16;
    localparam int EXP_W   = 17;
    localparam int IDX_W   = 6;
    localparam int FRAC_W  = 8;

    localparam int LOG2E_Q8 = 369;
    localparam int PROD_W   = LOGIT_W + 9;

    localparam logic [63:0] LN2_Q30 = 64'd744261118;

    localparam logic signed [LOGIT_W-1:0] MIN_LOGIT = 16'sh8000;

    typedef struct packed {
        logic signed [LOGIT_W-1:0] logit_value;
        logic                      vector_end;
    } t_logit_item;

    typedef struct packed {
        logic [IDX_W-1:0]  element_index;
        logic [PROB_W-1:0] probability;
        logic              run_end;
        logic              truncated;
    } t_prob_item;

endpackage

@@ sv/svu_stream_if.sv @@
// Valid/ready stream channel carrying one payload per transfer.
interface svu_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/softmax_vector_unit.sv @@
// Softmax vector unit: max-subtracted softmax over a stored vector of Q8.8 logits.
// Logits are taken one per cycle and stored while the running maximum is kept;
// elements arriving with the store full are dropped and flag the vector as
// truncated. The transfer marked vector_end closes the vector: the unit then
// stops taking input, computes the exponential of each of the N stored
// elements (element read, constant multiply, table lookup, shift and
// accumulate) and then each probability (exponential read, divider load, 17
// restoring-divide steps, output), waiting at the output while it is stalled.
// The one shared divider makes one quotient bit per cycle. No clearing pass is
// needed after reset.
module softmax_vector_unit #(
    parameter int MAX_LEN        = svu_pkg::DEF_MAX_LEN,
    parameter int EXP_TABLE_SIZE = svu_pkg::DEF_EXP_TABLE_SIZE
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    svu_stream_if.sink   i_in,
    svu_stream_if.source o_out
);
    import svu_pkg::*;

    `include "softmax_vector_unit_macros.svh"

    localparam int AW      = $clog2(MAX_LEN);
    localparam int CW      = $clog2(MAX_LEN + 1);
    localparam int SW      = EXP_W + AW;
    localparam int TW      = $clog2(EXP_TABLE_SIZE);
    localparam int M_W     = PROD_W - FRAC_W;
    localparam int S_W     = M_W + 1 - FRAC_W;
    localparam int SH_W    = 5;
    localparam int STEPS   = EXP_W;
    localparam int STEP_W  = $clog2(STEPS);

    typedef logic [EXP_W-1:0] t_table [EXP_TABLE_SIZE];

    // 2^(i/EXP_TABLE_SIZE) in Q1.16 by a Taylor series in Q30.
    function automatic logic [EXP_W-1:0] pow2_entry(input int unsigned i);
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] acc;
        z    = (64'(i) * LN2_Q30) / EXP_TABLE_SIZE;
        term = 64'd1 << 30;
        acc  = term;
        for (int n = 1; n <= 24; n++) begin
            term = (term * z) >> 30;
            case (n)
                1:  term = term / 1;
                2:  term = term / 2;
                3:  term = term / 3;
                4:  term = term / 4;
                5:  term = term / 5;
                6:  term = term / 6;
                7:  term = term / 7;
                8:  term = term / 8;
                9:  term = term / 9;
                10: term = term / 10;
                11: term = term / 11;
                12: term = term / 12;
                13: term = term / 13;
                14: term = term / 14;
                15: term = term / 15;
                16: term = term / 16;
                17: term = term / 17;
                18: term = term / 18;
                19: term = term / 19;
                20: term = term / 20;
                21: term = term / 21;
                22: term = term / 22;
                23: term = term / 23;
                24: term = term / 24;
                default: term = '0;
            endcase
            acc = acc + term;
        end
        return EXP_W'((acc + (64'd1 << 13)) >> 14);
    endfunction

    function automatic t_table build_table();
        t_table tab;
        for (int i = 0; i < EXP_TABLE_SIZE; i++) begin
            tab[i] = pow2_entry(i);
        end
        return tab;
    endfunction

    localparam t_table POW2_TABLE = build_table();

    typedef enum logic [3:0] {
        S_IN,
        S_EXP_RD,
        S_EXP_MUL,
        S_EXP_TAB,
        S_EXP_SH,
        S_DIV_RD,
        S_DIV_LOAD,
        S_DIV_STEP,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic signed [LOGIT_W-1:0] r_max, n_max;
    logic                      r_ovf, n_ovf;
    logic [AW-1:0]             r_idx, n_idx;
    logic [SW-1:0]             r_sum, n_sum;
    logic [PROD_W-1:0]         r_prod, n_prod;
    logic [EXP_W-1:0]          r_tab, n_tab;
    logic [SH_W-1:0]           r_shift, n_shift;
    logic                      r_zero, n_zero;
    logic [SW-1:0]             r_rem, n_rem;
    logic [EXP_W-1:0]          r_num, n_num;
    logic [EXP_W-1:0]          r_quo, n_quo;
    logic [STEP_W-1:0]         r_step, n_step;
    logic [IDX_W-1:0]          r_o_index, n_o_index;
    logic [PROB_W-1:0]         r_o_prob, n_o_prob;
    logic                      r_o_end, n_o_end;
    logic                      r_o_trunc, n_o_trunc;

    logic signed [LOGIT_W-1:0] r_elem_mem [MAX_LEN];
    logic [EXP_W-1:0]          r_exp_mem  [MAX_LEN];
    logic signed [LOGIT_W-1:0] r_elem_q;
    logic [EXP_W-1:0]          r_exp_q;

    logic                      elem_we;
    logic                      exp_we;
    logic [EXP_W-1:0]          exp_wdata;
    logic                      last_elem;
    logic [AW-1:0]             idx_inc;
    logic signed [LOGIT_W:0]   diff;
    logic [PROD_W-1:0]         m_sum;
    logic [M_W-1:0]            m_val;
    logic [M_W:0]              s_sum;
    logic [S_W-1:0]            s_val;
    logic [FRAC_W-1:0]         frac;
    logic [TW-1:0]             tidx;
    logic [SW+1:0]             trial;
    logic                      ge;
    logic [EXP_W-1:0]          quo_next;

    assign i_in.ready  = (r_state == S_IN);
    assign o_out.valid = (r_state == S_OUT);
    assign o_out.data.element_index = r_o_index;
    assign o_out.data.probability   = r_o_prob;
    assign o_out.data.run_end       = r_o_end;
    assign o_out.data.truncated     = r_o_trunc;

    assign elem_we   = i_in.valid && i_in.ready && (r_cnt < CW'(MAX_LEN));
    assign last_elem = ((CW'(r_idx) + CW'(1)) == r_cnt);
    assign idx_inc   = r_idx + AW'(1);

    assign diff  = {r_max[LOGIT_W-1], r_max} - {r_elem_q[LOGIT_W-1], r_elem_q};
    assign m_sum = r_prod + PROD_W'(255);
    assign m_val = m_sum[PROD_W-1:FRAC_W];
    assign s_sum = {1'b0, m_val} + (M_W + 1)'(255);
    assign s_val = s_sum[M_W:FRAC_W];
    assign frac  = FRAC_W'(9'h100 - {1'b0, m_val[FRAC_W-1:0]});
    assign tidx  = TW'((32'(frac) * 32'(EXP_TABLE_SIZE)) >> FRAC_W);

    assign exp_wdata = r_zero ? '0 : (r_tab >> r_shift);

    assign trial    = {1'b0, r_rem, r_num[EXP_W-1]} - {2'b00, r_sum};
    assign ge       = !trial[SW+1];
    assign quo_next = {r_quo[EXP_W-2:0], ge};

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_max     = r_max;
        n_ovf     = r_ovf;
        n_idx     = r_idx;
        n_sum     = r_sum;
        n_prod    = r_prod;
        n_tab     = r_tab;
        n_shift   = r_shift;
        n_zero    = r_zero;
        n_rem     = r_rem;
        n_num     = r_num;
        n_quo     = r_quo;
        n_step    = r_step;
        n_o_index = r_o_index;
        n_o_prob  = r_o_prob;
        n_o_end   = r_o_end;
        n_o_trunc = r_o_trunc;
        exp_we    = 1'b0;
        case (r_state)
            S_IN: begin
                if (i_in.valid) begin
                    if (r_cnt < CW'(MAX_LEN)) begin
                        n_cnt = r_cnt + CW'(1);
                        if (i_in.data.logit_value > r_max) begin
                            n_max = i_in.data.logit_value;
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.data.vector_end) begin
                        n_state = S_EXP_RD;
                        n_idx   = '0;
                        n_sum   = '0;
                    end
                end
            end
            S_EXP_RD: begin
                n_state = S_EXP_MUL;
            end
            S_EXP_MUL: begin
                n_prod  = PROD_W'(diff[LOGIT_W-1:0]) * PROD_W'(LOG2E_Q8);
                n_state = S_EXP_TAB;
            end
            S_EXP_TAB: begin
                n_tab   = POW2_TABLE[tidx];
                n_shift = s_val[SH_W-1:0];
                n_zero  = |s_val[S_W-1:SH_W];
                n_state = S_EXP_SH;
            end
            S_EXP_SH: begin
                exp_we = 1'b1;
                n_sum  = r_sum + SW'(exp_wdata);
                if (last_elem) begin
                    n_idx   = '0;
                    n_state = S_DIV_RD;
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_EXP_RD;
                end
            end
            S_DIV_RD: begin
                n_state = S_DIV_LOAD;
            end
            S_DIV_LOAD: begin
                n_rem   = SW'(r_exp_q >> 1);
                n_num   = {r_exp_q[0], {(EXP_W-1){1'b0}}};
                n_quo   = '0;
                n_step  = '0;
                n_state = S_DIV_STEP;
            end
            S_DIV_STEP: begin
                n_rem  = ge ? trial[SW-1:0] : {r_rem[SW-2:0], r_num[EXP_W-1]};
                n_num  = {r_num[EXP_W-2:0], 1'b0};
                n_quo  = quo_next;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(STEPS - 1)) begin
                    n_o_index = IDX_W'(r_idx);
                    n_o_prob  = quo_next[EXP_W-1] ? '1 : quo_next[PROB_W-1:0];
                    n_o_end   = last_elem;
                    n_o_trunc = r_ovf;
                    n_state   = S_OUT;
                end
            end
            S_OUT: begin
                if (o_out.ready) begin
                    if (r_o_end) begin
                        n_cnt   = '0;
                        n_max   = MIN_LOGIT;
                        n_ovf   = 1'b0;
                        n_state = S_IN;
                    end else begin
                        n_idx   = idx_inc;
                        n_state = S_DIV_RD;
                    end
                end
            end
            default: begin
                n_state = S_IN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_cnt   <= '0;
            r_max   <= MIN_LOGIT;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_max   <= n_max;
            r_ovf   <= n_ovf;
        end
        r_idx     <= n_idx;
        r_sum     <= n_sum;
        r_prod    <= n_prod;
        r_tab     <= n_tab;
        r_shift   <= n_shift;
        r_zero    <= n_zero;
        r_rem     <= n_rem;
        r_num     <= n_num;
        r_quo     <= n_quo;
        r_step    <= n_step;
        r_o_index <= n_o_index;
        r_o_prob  <= n_o_prob;
        r_o_end   <= n_o_end;
        r_o_trunc <= n_o_trunc;
    end

    always_ff @(posedge i_clk) begin
        if (elem_we) begin
            r_elem_mem[r_cnt[AW-1:0]] <= i_in.data.logit_value;
        end
        r_elem_q <= r_elem_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (exp_we) begin
            r_exp_mem[r_idx] <= exp_wdata;
        end
        r_exp_q <= r_exp_mem[r_idx];
    end

    `SVU_ASSERT_IMPL(a_ready_excl_valid, i_clk, i_rst_n, i_in.ready, !o_out.valid)
    `SVU_ASSERT_IMPL(a_cnt_in_range, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(MAX_LEN))
    `SVU_ASSERT_IMPL(a_rem_below_sum, i_clk, i_rst_n, r_state == S_DIV_STEP, r_rem < r_sum)
    `SVU_ASSERT_NEXT(a_end_reopens, i_clk, i_rst_n, o_out.valid && o_out.ready && o_out.data.run_end, i_in.ready && (r_cnt == '0))

endmodule

@@ verif/tb_softmax_vector_unit.sv @@
// Testbench for softmax_vector_unit: random and directed logit vectors checked against a softmax predictor.
module tb_softmax_vector_unit;
    import svu_pkg::*;

    localparam int STORE_DEPTH  = DEF_MAX_LEN;
    localparam int TABLE_SIZE   = DEF_EXP_TABLE_SIZE;
    localparam int TARGET_ITEMS = 420;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 500000;

    class prob_scoreboard;
        logic [31:0]               pow2_q16[TABLE_SIZE];
        logic signed [LOGIT_W-1:0] logit_store[STORE_DEPTH];
        logic [EXP_W-1:0]          weight[STORE_DEPTH];
        int                        stored;
        logic signed [LOGIT_W-1:0] peak;
        logic                      dropped;
        t_prob_item                expected_probs[$];
        int                        errors;

        function new();
            longint unsigned z, term, acc;
            for (int i = 0; i < TABLE_SIZE; i++) begin
                z    = (longint'(i) * LN2_Q30) / TABLE_SIZE;
                term = 64'd1 << 30;
                acc  = term;
                for (int n = 1; n <= 24; n++) begin
                    term = (term * z) >> 30;
                    term = term / n;
                    acc  = acc + term;
                end
                pow2_q16[i] = 32'((acc + (64'd1 << 13)) >> 14);
            end
            errors = 0;
            clear_vector();
        endfunction

        function void clear_vector();
            stored  = 0;
            peak    = MIN_LOGIT;
            dropped = 1'b0;
        endfunction

        // exp(d) as 2^(d*log2e), d <= 0, Q1.16
        function logic [EXP_W-1:0] exp_weight(int d);
            int unsigned n, m, s, f, idx;
            n   = (d < 0) ? -d : 0;
            m   = (n * LOG2E_Q8 + 255) >> 8;
            s   = (m + 255) >> 8;
            f   = (s << 8) - m;
            idx = (f * TABLE_SIZE) >> 8;
            if (idx >= TABLE_SIZE) idx = TABLE_SIZE - 1;
            if (s >= 32) return '0;
            return EXP_W'(pow2_q16[idx] >> s);
        endfunction

        function void note_logit(logic signed [LOGIT_W-1:0] v, logic last);
            longint unsigned sum, q;
            t_prob_item      p;
            if (stored < STORE_DEPTH) begin
                logit_store[stored] = v;
                stored++;
                if (v > peak) peak = v;
            end else begin
                dropped = 1'b1;
            end
            if (!last) return;
            sum = 0;
            for (int i = 0; i < stored; i++) begin
                weight[i] = exp_weight(int'(logit_store[i]) - int'(peak));
                sum += weight[i];
            end
            for (int i = 0; i < stored; i++) begin
                q = (longint'(weight[i]) << 16) / sum;
                if (q > 65535) q = 65535;
                p.element_index = IDX_W'(i);
                p.probability   = PROB_W'(q);
                p.run_end       = (i + 1 == stored);
                p.truncated     = dropped;
                expected_probs.push_back(p);
            end
            clear_vector();
        endfunction

        function void check_prob(t_prob_item got);
            t_prob_item want;
            if (expected_probs.size() == 0) begin
                $display("ERROR t=%0t unexpected result: expected none, actual idx %0d prob %0d",
                         $time, got.element_index, got.probability);
                errors++;
                return;
            end
            want = expected_probs.pop_front();
            if (got.element_index !== want.element_index) begin
                $display("ERROR t=%0t element_index: expected %0d, actual %0d",
                         $time, want.element_index, got.element_index);
                errors++;
            end
            if (got.probability !== want.probability) begin
                $display("ERROR t=%0t probability: expected %0d, actual %0d",
                         $time, want.probability, got.probability);
                errors++;
            end
            if (got.run_end !== want.run_end) begin
                $display("ERROR t=%0t run_end: expected %0b, actual %0b",
                         $time, want.run_end, got.run_end);
                errors++;
            end
            if (got.truncated !== want.truncated) begin
                $display("ERROR t=%0t truncated: expected %0b, actual %0b",
                         $time, want.truncated, got.truncated);
                errors++;
            end
        endfunction

        function int pending();
            return expected_probs.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    svu_stream_if #(.T(t_logit_item)) logit_ch ();
    svu_stream_if #(.T(t_prob_item))  prob_ch ();

    softmax_vector_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (logit_ch),
        .o_out   (prob_ch)
    );

    prob_scoreboard sb = new();
    int             cycles       = 0;
    int             results_seen = 0;
    int             items_sent   = 0;
    bit             send_quiet   = 1'b0;
    logic signed [LOGIT_W-1:0] vec[$];

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("softmax_vector_unit: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && prob_ch.valid && prob_ch.ready) begin
            sb.check_prob(prob_ch.data);
            results_seen++;
        end
    end

    // sink side: random stalls, quiet stretches, one long hold-off
    initial begin
        int  stall_left, phase_left, r;
        bit  held, quiet;
        stall_left    = 0;
        phase_left    = 0;
        held          = 1'b0;
        quiet         = 1'b0;
        prob_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (phase_left == 0) begin
                quiet      = ($urandom_range(0, 2) == 0);
                phase_left = $urandom_range(50, 300);
            end
            phase_left--;
            if (stall_left > 0) begin
                prob_ch.ready = 1'b0;
                stall_left--;
            end else if (!held && results_seen >= 3) begin
                held          = 1'b1;
                prob_ch.ready = 1'b0;
                stall_left    = HOLD_CYCLES - 1;
            end else if (quiet) begin
                prob_ch.ready = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    prob_ch.ready = 1'b1;
                end else if (r < 95) begin
                    prob_ch.ready = 1'b0;
                    stall_left    = $urandom_range(0, 2);
                end else begin
                    prob_ch.ready = 1'b0;
                    stall_left    = $urandom_range(10, 50);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (send_quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // entered right after the previous transfer's rising edge
    task automatic send_logit(logic signed [LOGIT_W-1:0] v, logic last);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            logit_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        logit_ch.valid = 1'b1;
        logit_ch.data  = '{logit_value: v, vector_end: last};
        do @(posedge i_clk); while (!logit_ch.ready);
        sb.note_logit(v, last);
        items_sent++;
    endtask

    task automatic send_vector();
        foreach (vec[i]) send_logit(vec[i], i == vec.size() - 1);
        vec.delete();
    endtask

    function automatic logic signed [LOGIT_W-1:0] rand_logit(int center);
        if ($urandom_range(0, 99) < 40) return LOGIT_W'($urandom);
        return LOGIT_W'(center + $urandom_range(0, 2047) - 1024);
    endfunction

    initial begin
        int len, center, r;
        i_rst_n        = 1'b0;
        logit_ch.valid = 1'b0;
        logit_ch.data  = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        vec = '{16'sd32767};                    send_vector();
        vec = '{-16'sd32768};                   send_vector();
        vec = '{-16'sd32768, 16'sd32767};       send_vector();
        vec = '{16'sd0, 16'sd0, 16'sd0};        send_vector();
        vec = '{-16'sd1, 16'sd0, 16'sd256, -16'sd256, 16'sd1};      send_vector();
        // shifts around the zero cutoff at a shift of 32
        vec = '{16'sd0, -16'sd5500, -16'sd5700, -16'sd5900};       send_vector();
        vec = '{-16'sd32768, -16'sd32767, -16'sd32768};            send_vector();

        while (items_sent < TARGET_ITEMS) begin
            send_quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 70)      len = $urandom_range(1, 8);
            else if (r < 90) len = $urandom_range(9, 40);
            else if (r < 96) len = $urandom_range(41, STORE_DEPTH);
            else             len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 6);
            center = $urandom_range(0, 65535) - 32768;
            repeat (len) vec.push_back(rand_logit(center));
            send_vector();
        end

        @(negedge i_clk);
        logit_ch.valid = 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("softmax_vector_unit: match");
        else
            $display("softmax_vector_unit: mismatch");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+sv
sv/svu_pkg.sv
sv/svu_stream_if.sv
sv/softmax_vector_unit.sv
verif/tb_softmax_vector_unit.sv
